// ===== sv/mic_pkg.sv =====
package mic_pkg;

   typedef enum logic [5:0] {
      OPC_NONE    = 6'd0,
      OPC_NOP     = 6'd1,
      OPC_SLL     = 6'd2,
      OPC_SRL     = 6'd3,
      OPC_SRA     = 6'd4,
      OPC_SLLV    = 6'd5,
      OPC_SRLV    = 6'd6,
      OPC_SRAV    = 6'd7,
      OPC_JR      = 6'd8,
      OPC_JALR    = 6'd9,
      OPC_SYSCALL = 6'd10,
      OPC_BREAK   = 6'd11,
      OPC_ADDU    = 6'd12,
      OPC_SUBU    = 6'd13,
      OPC_AND     = 6'd14,
      OPC_OR      = 6'd15,
      OPC_XOR     = 6'd16,
      OPC_NOR     = 6'd17,
      OPC_SLT     = 6'd18,
      OPC_SLTU    = 6'd19,
      OPC_BLTZ    = 6'd20,
      OPC_BGEZ    = 6'd21,
      OPC_BLTZAL  = 6'd22,
      OPC_BGEZAL  = 6'd23,
      OPC_J       = 6'd24,
      OPC_JAL     = 6'd25,
      OPC_BEQ     = 6'd26,
      OPC_BNE     = 6'd27,
      OPC_BLEZ    = 6'd28,
      OPC_BGTZ    = 6'd29,
      OPC_ADDIU   = 6'd30,
      OPC_SLTI    = 6'd31,
      OPC_SLTIU   = 6'd32,
      OPC_ANDI    = 6'd33,
      OPC_ORI     = 6'd34,
      OPC_XORI    = 6'd35,
      OPC_LUI     = 6'd36,
      OPC_COP0    = 6'd37,
      OPC_COP2    = 6'd38,
      OPC_LB      = 6'd39,
      OPC_LH      = 6'd40,
      OPC_LW      = 6'd41,
      OPC_LBU     = 6'd42,
      OPC_LHU     = 6'd43,
      OPC_SB      = 6'd44,
      OPC_SH      = 6'd45,
      OPC_SW      = 6'd46
   } opcode_type;

   localparam logic [5:0] PRI_SPECIAL = 6'h00;
   localparam logic [5:0] PRI_REGIMM  = 6'h01;
   localparam logic [5:0] PRI_J       = 6'h02;
   localparam logic [5:0] PRI_JAL     = 6'h03;
   localparam logic [5:0] PRI_BEQ     = 6'h04;
   localparam logic [5:0] PRI_BNE     = 6'h05;
   localparam logic [5:0] PRI_BLEZ    = 6'h06;
   localparam logic [5:0] PRI_BGTZ    = 6'h07;
   localparam logic [5:0] PRI_ADDIU   = 6'h09;
   localparam logic [5:0] PRI_SLTI    = 6'h0A;
   localparam logic [5:0] PRI_SLTIU   = 6'h0B;
   localparam logic [5:0] PRI_ANDI    = 6'h0C;
   localparam logic [5:0] PRI_ORI     = 6'h0D;
   localparam logic [5:0] PRI_XORI    = 6'h0E;
   localparam logic [5:0] PRI_LUI     = 6'h0F;
   localparam logic [5:0] PRI_COP0    = 6'h10;
   localparam logic [5:0] PRI_COP2    = 6'h12;
   localparam logic [5:0] PRI_LB      = 6'h20;
   localparam logic [5:0] PRI_LH      = 6'h21;
   localparam logic [5:0] PRI_LW      = 6'h23;
   localparam logic [5:0] PRI_LBU     = 6'h24;
   localparam logic [5:0] PRI_LHU     = 6'h25;
   localparam logic [5:0] PRI_SB      = 6'h28;
   localparam logic [5:0] PRI_SH      = 6'h29;
   localparam logic [5:0] PRI_SW      = 6'h2B;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_SLLV    = 6'h04;
   localparam logic [5:0] FN_SRLV    = 6'h06;
   localparam logic [5:0] FN_SRAV    = 6'h07;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_BREAK   = 6'h0D;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2A;
   localparam logic [5:0] FN_SLTU    = 6'h2B;

   localparam logic [4:0] RT_BLTZ   = 5'h00;
   localparam logic [4:0] RT_BGEZ   = 5'h01;
   localparam logic [4:0] RT_BLTZAL = 5'h10;
   localparam logic [4:0] RT_BGEZAL = 5'h11;

   typedef struct packed {
      logic [31:0] instruction_word;
      logic [31:0] pc;
   } req_type;

   typedef struct packed {
      logic        needs_fallback;
      logic        memory_access;
      logic        exception_possible;
      logic        unconditional_flag;
      logic        branch_flag;
      logic [31:0] branch_target;
      logic [15:0] immediate;
      logic [4:0]  shift_amount;
      logic [4:0]  dst_reg;
      logic [4:0]  tgt_reg;
      logic [4:0]  src_reg;
      opcode_type  operation_code;
   } rsp_type;

endpackage

// ===== sv/mic_decode.sv =====
module mic_decode (
   input  mic_pkg::req_type req,
   output mic_pkg::rsp_type rsp
);

   logic [31:0]         word;
   logic [5:0]          primary;
   logic [5:0]          funct;
   logic [4:0]          rt;
   logic [31:0]         next_pc;
   logic [31:0]         offset;
   mic_pkg::opcode_type op;

   assign word    = req.instruction_word;
   assign primary = word[31:26];
   assign funct   = word[5:0];
   assign rt      = word[20:16];
   assign next_pc = req.pc + 32'd4;
   assign offset  = {{14{word[15]}}, word[15:0], 2'b00};

   always_comb begin
      op = mic_pkg::OPC_NONE;
      case (primary)
         mic_pkg::PRI_SPECIAL: begin
            case (funct)
               mic_pkg::FN_SLL:     op = (word == 32'd0) ? mic_pkg::OPC_NOP : mic_pkg::OPC_SLL;
               mic_pkg::FN_SRL:     op = mic_pkg::OPC_SRL;
               mic_pkg::FN_SRA:     op = mic_pkg::OPC_SRA;
               mic_pkg::FN_SLLV:    op = mic_pkg::OPC_SLLV;
               mic_pkg::FN_SRLV:    op = mic_pkg::OPC_SRLV;
               mic_pkg::FN_SRAV:    op = mic_pkg::OPC_SRAV;
               mic_pkg::FN_JR:      op = mic_pkg::OPC_JR;
               mic_pkg::FN_JALR:    op = mic_pkg::OPC_JALR;
               mic_pkg::FN_SYSCALL: op = mic_pkg::OPC_SYSCALL;
               mic_pkg::FN_BREAK:   op = mic_pkg::OPC_BREAK;
               mic_pkg::FN_ADDU:    op = mic_pkg::OPC_ADDU;
               mic_pkg::FN_SUBU:    op = mic_pkg::OPC_SUBU;
               mic_pkg::FN_AND:     op = mic_pkg::OPC_AND;
               mic_pkg::FN_OR:      op = mic_pkg::OPC_OR;
               mic_pkg::FN_XOR:     op = mic_pkg::OPC_XOR;
               mic_pkg::FN_NOR:     op = mic_pkg::OPC_NOR;
               mic_pkg::FN_SLT:     op = mic_pkg::OPC_SLT;
               mic_pkg::FN_SLTU:    op = mic_pkg::OPC_SLTU;
               default:             op = mic_pkg::OPC_NONE;
            endcase
         end
         mic_pkg::PRI_REGIMM: begin
            case (rt)
               mic_pkg::RT_BLTZ:   op = mic_pkg::OPC_BLTZ;
               mic_pkg::RT_BGEZ:   op = mic_pkg::OPC_BGEZ;
               mic_pkg::RT_BLTZAL: op = mic_pkg::OPC_BLTZAL;
               mic_pkg::RT_BGEZAL: op = mic_pkg::OPC_BGEZAL;
               default:            op = mic_pkg::OPC_NONE;
            endcase
         end
         mic_pkg::PRI_J:     op = mic_pkg::OPC_J;
         mic_pkg::PRI_JAL:   op = mic_pkg::OPC_JAL;
         mic_pkg::PRI_BEQ:   op = mic_pkg::OPC_BEQ;
         mic_pkg::PRI_BNE:   op = mic_pkg::OPC_BNE;
         mic_pkg::PRI_BLEZ:  op = mic_pkg::OPC_BLEZ;
         mic_pkg::PRI_BGTZ:  op = mic_pkg::OPC_BGTZ;
         mic_pkg::PRI_ADDIU: op = mic_pkg::OPC_ADDIU;
         mic_pkg::PRI_SLTI:  op = mic_pkg::OPC_SLTI;
         mic_pkg::PRI_SLTIU: op = mic_pkg::OPC_SLTIU;
         mic_pkg::PRI_ANDI:  op = mic_pkg::OPC_ANDI;
         mic_pkg::PRI_ORI:   op = mic_pkg::OPC_ORI;
         mic_pkg::PRI_XORI:  op = mic_pkg::OPC_XORI;
         mic_pkg::PRI_LUI:   op = mic_pkg::OPC_LUI;
         mic_pkg::PRI_COP0:  op = mic_pkg::OPC_COP0;
         mic_pkg::PRI_COP2:  op = mic_pkg::OPC_COP2;
         mic_pkg::PRI_LB:    op = mic_pkg::OPC_LB;
         mic_pkg::PRI_LH:    op = mic_pkg::OPC_LH;
         mic_pkg::PRI_LW:    op = mic_pkg::OPC_LW;
         mic_pkg::PRI_LBU:   op = mic_pkg::OPC_LBU;
         mic_pkg::PRI_LHU:   op = mic_pkg::OPC_LHU;
         mic_pkg::PRI_SB:    op = mic_pkg::OPC_SB;
         mic_pkg::PRI_SH:    op = mic_pkg::OPC_SH;
         mic_pkg::PRI_SW:    op = mic_pkg::OPC_SW;
         default:            op = mic_pkg::OPC_NONE;
      endcase
   end

   always_comb begin
      rsp.operation_code     = op;
      rsp.src_reg            = word[25:21];
      rsp.tgt_reg            = word[20:16];
      rsp.dst_reg            = word[15:11];
      rsp.shift_amount       = word[10:6];
      rsp.immediate          = word[15:0];
      rsp.branch_target      = 32'd0;
      rsp.branch_flag        = 1'b0;
      rsp.unconditional_flag = 1'b0;
      rsp.exception_possible = 1'b0;
      rsp.memory_access      = 1'b0;
      rsp.needs_fallback     = (op inside {mic_pkg::OPC_NONE, mic_pkg::OPC_COP0,
                                           mic_pkg::OPC_COP2});
      if (op inside {mic_pkg::OPC_JR, mic_pkg::OPC_JALR}) begin
         rsp.branch_flag        = 1'b1;
         rsp.unconditional_flag = 1'b1;
      end else if (op inside {mic_pkg::OPC_J, mic_pkg::OPC_JAL}) begin
         rsp.branch_flag        = 1'b1;
         rsp.unconditional_flag = 1'b1;
         rsp.branch_target      = {next_pc[31:28], word[25:0], 2'b00};
      end else if (op inside {[mic_pkg::OPC_BLTZ:mic_pkg::OPC_BGEZAL],
                              [mic_pkg::OPC_BEQ:mic_pkg::OPC_BGTZ]}) begin
         rsp.branch_flag   = 1'b1;
         rsp.branch_target = next_pc + offset;
      end else if (op inside {mic_pkg::OPC_SYSCALL, mic_pkg::OPC_BREAK}) begin
         rsp.exception_possible = 1'b1;
      end else if (op inside {[mic_pkg::OPC_LB:mic_pkg::OPC_SW]}) begin
         rsp.exception_possible = 1'b1;
         rsp.memory_access      = 1'b1;
      end
   end

endmodule

// ===== sv/mips_instruction_classifier.sv =====
// Channel   Dir  Width  Contents
// req       in   64     pc, instruction_word
// rsp       out  80     decoded fields, branch target and flags
//
// Two register stages: the input register holds the accepted beat, the decode
// logic runs between it and the result register.
// Beats pass the input register, then the result register; one per cycle unless stalled.
// While the result register is stalled, one more beat is still accepted.
// Reset clears both valid bits; payload registers are not reset.
module mips_instruction_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] pc, [63:32] instruction_word
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] operation_code, [10:6] src_reg, [15:11] tgt_reg, [20:16] dst_reg,
   // [25:21] shift_amount, [41:26] immediate, [73:42] branch_target,
   // [74] branch_flag, [75] unconditional_flag, [76] exception_possible,
   // [77] memory_access, [78] needs_fallback, [79] zero
   output logic [79:0] rsp_tdata
);

   logic             in_valid_ff;
   logic             in_valid_in;
   mic_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   mic_pkg::rsp_type out_data_ff;
   mic_pkg::rsp_type decoded;
   logic             advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         out_data_ff <= decoded;
      end
   end

   mic_decode u_decode (
      .req (in_data_ff),
      .rsp (decoded)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted beat did not reach the input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |=> (in_valid_ff && out_valid_ff))
      else $error("input register lost a beat during a stall");

   a_target_branch: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.branch_target != 32'd0) |-> out_data_ff.branch_flag)
      else $error("branch target set on a non-branch");

   a_fallback_plain: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.needs_fallback) |->
      (!out_data_ff.branch_flag && !out_data_ff.exception_possible))
      else $error("fallback beat carries branch or exception flags");

endmodule
